// ----- rtl/core/scu_pkg.sv -----
// Shared constants, types and latency figures of the smoothing curve unit.
package scu_pkg;

    // Default number of fraction bits of the sample and result words.
    localparam int FRACTION_BITS_DEF = 16;

    // Internal words are Q2.62: 2^62 stands for 1.0.
    localparam int Q_BITS = 64;
    localparam int Q_FRAC = 62;
    localparam logic [Q_BITS-1:0] Q62_ONE = 64'h4000_0000_0000_0000;

    // pi in Q4.60.
    localparam logic [Q_BITS-1:0] PI_Q60 = 64'h3243_F6A8_885A_308D;

    // Every multiplier is two register stages deep.
    localparam int MUL_LAT = 2;

    // One series term: product, reciprocal product, check product, fix-up register.
    localparam int TERM_LAT = 3 * MUL_LAT + 1;

    // The sine series sums twelve terms, which takes eleven term updates.
    localparam int SERIES_TERMS = 12;
    localparam int SERIES_DIVS  = SERIES_TERMS - 1;

    // Reciprocal constants are floor(2^RECIP_SHIFT / divisor).
    localparam int RECIP_SHIFT  = 74;
    localparam int RECIP_BITS   = 72;
    localparam int DIVISOR_BITS = 10;

    // Sine path: angle product, square, series, final scale.
    localparam int SINE_LAT = 2 * MUL_LAT + SERIES_DIVS * TERM_LAT + MUL_LAT;

    typedef logic [Q_BITS-1:0] qword_t;

    typedef enum logic [2:0] {
        MODE_QUINTIC     = 3'd0,
        MODE_SEPTIC      = 3'd1,
        MODE_SINE        = 3'd2,
        MODE_CUBIC_RAT   = 3'd3,
        MODE_QUARTIC_RAT = 3'd4
    } curve_mode_t;

    // Divisor that forms Taylor term k+1 of sin(t)/t from term k: (2k+2)(2k+3).
    function automatic int series_divisor(input int k);
        return (2 * k + 2) * (2 * k + 3);
    endfunction

endpackage

// ----- rtl/core/scu_mul.sv -----
// Two-stage multiplier built from 32 by 32 bit partial products.
module scu_mul #(
    parameter int WA = 64,
    parameter int WB = 64
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [WA-1:0]    a,
    input  logic [WB-1:0]    b,
    output logic [WA+WB-1:0] p
);
    localparam int CH = 32;
    localparam int NA = (WA + CH - 1) / CH;
    localparam int NB = (WB + CH - 1) / CH;
    localparam int WP = WA + WB;

    logic [NA*CH-1:0] a_ext;
    logic [NB*CH-1:0] b_ext;
    logic [2*CH-1:0]  part_reg [NA*NB];
    logic [WP-1:0]    p_next;
    logic [WP-1:0]    p_reg;

    assign a_ext = (NA*CH)'(a);
    assign b_ext = (NB*CH)'(b);

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    part_reg[i*NB+j] <= a_ext[i*CH +: CH] * b_ext[j*CH +: CH];
                end
            end
            p_reg <= p_next;
        end
    end

    // Bits above WP are zero in the true product, so wrapping is exact.
    always_comb begin
        p_next = '0;
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                p_next = p_next + (WP'(part_reg[i*NB+j]) << ((i + j) * CH));
            end
        end
    end

    assign p = p_reg;

endmodule

// ----- rtl/core/scu_delay.sv -----
// Shift line that delays a word by a fixed number of pipeline stages.
module scu_delay #(
    parameter int W     = 1,
    parameter int DEPTH = 1
) (
    input  logic         aclk,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);
    generate
        if (DEPTH == 0) begin : g_none
            assign q = d;
        end else begin : g_line
            logic [W-1:0] line_reg [DEPTH];

            always_ff @(posedge aclk) begin
                if (en) begin
                    line_reg[0] <= d;
                    for (int k = 1; k < DEPTH; k++) begin
                        line_reg[k] <= line_reg[k-1];
                    end
                end
            end

            assign q = line_reg[DEPTH-1];
        end
    endgenerate

endmodule

// ----- rtl/core/scu_term.sv -----
// One update of the sine series: add or subtract a term, form the next term.
module scu_term #(
    parameter int K = 0
) (
    input  logic            aclk,
    input  logic            en,
    input  scu_pkg::qword_t t_in,
    input  scu_pkg::qword_t w_in,
    input  scu_pkg::qword_t s_in,
    output scu_pkg::qword_t t_out,
    output scu_pkg::qword_t w_out,
    output scu_pkg::qword_t s_out
);
    import scu_pkg::*;

    localparam int DIVISOR = series_divisor(K);
    localparam logic [127:0] RECIP_FULL = (128'd1 << RECIP_SHIFT) / 128'(DIVISOR);
    localparam logic [RECIP_BITS-1:0] RECIP = RECIP_FULL[RECIP_BITS-1:0];
    localparam int WP2 = Q_BITS + RECIP_BITS;

    logic [2*Q_BITS-1:0]            p1;
    logic [WP2-1:0]                 p2;
    logic [Q_BITS+DIVISOR_BITS-1:0] p3;
    qword_t n, n_d, q0, q0_d, rem, s_next, t_next, t_reg;

    // Even terms add, odd terms subtract with a floor at zero.
    always_comb begin
        if (K % 2 == 0) begin
            s_next = s_in + t_in;
        end else begin
            s_next = (s_in >= t_in) ? s_in - t_in : '0;
        end
    end

    scu_delay #(.W(Q_BITS), .DEPTH(TERM_LAT)) u_s_dly (
        .aclk(aclk), .en(en), .d(s_next), .q(s_out));
    scu_delay #(.W(Q_BITS), .DEPTH(TERM_LAT)) u_w_dly (
        .aclk(aclk), .en(en), .d(w_in), .q(w_out));

    scu_mul #(.WA(Q_BITS), .WB(Q_BITS)) u_mul_tw (
        .aclk(aclk), .en(en), .a(t_in), .b(w_in), .p(p1));
    assign n = p1[Q_FRAC+Q_BITS-1:Q_FRAC];

    // Quotient estimate by reciprocal; it is low by at most one.
    scu_mul #(.WA(Q_BITS), .WB(RECIP_BITS)) u_mul_recip (
        .aclk(aclk), .en(en), .a(n), .b(RECIP), .p(p2));
    assign q0 = Q_BITS'(p2[WP2-1:RECIP_SHIFT]);

    scu_mul #(.WA(Q_BITS), .WB(DIVISOR_BITS)) u_mul_check (
        .aclk(aclk), .en(en), .a(q0), .b(DIVISOR_BITS'(DIVISOR)), .p(p3));

    scu_delay #(.W(Q_BITS), .DEPTH(2 * MUL_LAT)) u_n_dly (
        .aclk(aclk), .en(en), .d(n), .q(n_d));
    scu_delay #(.W(Q_BITS), .DEPTH(MUL_LAT)) u_q0_dly (
        .aclk(aclk), .en(en), .d(q0), .q(q0_d));

    assign rem    = n_d - p3[Q_BITS-1:0];
    assign t_next = (rem >= Q_BITS'(DIVISOR)) ? q0_d + 64'd1 : q0_d;

    always_ff @(posedge aclk) begin
        if (en) begin
            t_reg <= t_next;
        end
    end

    assign t_out = t_reg;

endmodule

// ----- rtl/core/scu_sine.sv -----
// Sine-corrected curve x - sin(2 pi x)/(2 pi), before rounding.
module scu_sine #(
    parameter int FRACTION_BITS = scu_pkg::FRACTION_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   en,
    input  logic [FRACTION_BITS:0] xc,
    output scu_pkg::qword_t        f
);
    import scu_pkg::*;

    localparam int XW = FRACTION_BITS + 1;
    localparam int XQ_SHIFT = Q_FRAC - FRACTION_BITS;
    localparam logic [XW-1:0] ONE_CODE = XW'(1) << FRACTION_BITS;
    localparam logic [XW-1:0] HALF     = ONE_CODE >> 1;
    localparam logic [XW-1:0] QUARTER  = ONE_CODE >> 2;

    logic [XW-1:0]          u, u_d, xc_d, xc_e;
    logic                   add, add_d, add_e;
    logic [Q_BITS+XW-1:0]   p_theta;
    logic [2*Q_BITS-1:0]    p_w, p_g;
    qword_t theta, w, s_final, g, xq_e;
    qword_t t_chain [SERIES_DIVS+1];
    qword_t w_chain [SERIES_DIVS+1];
    qword_t s_chain [SERIES_DIVS+1];

    // Fold x into the first quarter wave; the upper half adds the correction.
    always_comb begin
        if (xc <= QUARTER) begin
            u = xc;          add = 1'b0;
        end else if (xc <= HALF) begin
            u = HALF - xc;   add = 1'b0;
        end else if (xc <= HALF + QUARTER) begin
            u = xc - HALF;   add = 1'b1;
        end else begin
            u = ONE_CODE - xc; add = 1'b1;
        end
    end

    scu_mul #(.WA(Q_BITS), .WB(XW)) u_mul_theta (
        .aclk(aclk), .en(en), .a(PI_Q60), .b(u), .p(p_theta));
    assign theta = p_theta[FRACTION_BITS-3 +: Q_BITS];

    scu_mul #(.WA(Q_BITS), .WB(Q_BITS)) u_mul_w (
        .aclk(aclk), .en(en), .a(theta), .b(theta), .p(p_w));
    assign w = p_w[Q_FRAC+Q_BITS-1:Q_FRAC];

    assign t_chain[0] = Q62_ONE;
    assign s_chain[0] = '0;
    assign w_chain[0] = w;

    generate
        for (genvar k = 0; k < SERIES_DIVS; k++) begin : g_term
            scu_term #(.K(k)) u_term (
                .aclk (aclk),
                .en   (en),
                .t_in (t_chain[k]),
                .w_in (w_chain[k]),
                .s_in (s_chain[k]),
                .t_out(t_chain[k+1]),
                .w_out(w_chain[k+1]),
                .s_out(s_chain[k+1])
            );
        end
    endgenerate

    // The last term is odd and only subtracts.
    assign s_final = (s_chain[SERIES_DIVS] >= t_chain[SERIES_DIVS]) ?
                     s_chain[SERIES_DIVS] - t_chain[SERIES_DIVS] : '0;

    scu_delay #(.W(2 * XW + 1), .DEPTH(SINE_LAT - MUL_LAT)) u_arg_dly (
        .aclk(aclk), .en(en), .d({add, xc, u}), .q({add_d, xc_d, u_d}));
    scu_delay #(.W(XW + 1), .DEPTH(MUL_LAT)) u_sel_dly (
        .aclk(aclk), .en(en), .d({add_d, xc_d}), .q({add_e, xc_e}));

    scu_mul #(.WA(Q_BITS), .WB(Q_BITS)) u_mul_g (
        .aclk(aclk), .en(en), .a(Q_BITS'(u_d) << XQ_SHIFT), .b(s_final), .p(p_g));
    assign g = p_g[Q_FRAC+Q_BITS-1:Q_FRAC];

    assign xq_e = Q_BITS'(xc_e) << XQ_SHIFT;
    assign f = add_e ? xq_e + g : ((xq_e >= g) ? xq_e - g : '0);

endmodule

// ----- rtl/core/scu_div.sv -----
// Pipelined restoring divider for the rational curves, one quotient bit a stage.
module scu_div #(
    parameter int FRACTION_BITS = scu_pkg::FRACTION_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   en,
    input  scu_pkg::qword_t        num,
    input  scu_pkg::qword_t        oth,
    output logic [FRACTION_BITS:0] code
);
    import scu_pkg::*;

    localparam int XW = FRACTION_BITS + 1;
    localparam int QW = FRACTION_BITS + 2;
    localparam int NSTEP = FRACTION_BITS + 2;
    localparam int RW = Q_BITS + 1;
    localparam logic [XW-1:0] ONE_CODE = XW'(1) << FRACTION_BITS;

    logic [RW-1:0] rem_reg [NSTEP+1];
    logic [RW-1:0] d_reg   [NSTEP+1];
    logic [QW-1:0] q_reg   [NSTEP+1];
    logic [QW:0]   q_round;

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= RW'(num);
            d_reg[0]   <= RW'(num) + RW'(oth);
            q_reg[0]   <= '0;
        end
    end

    generate
        for (genvar j = 0; j < NSTEP; j++) begin : g_step
            logic [RW-1:0] r_sh;
            logic [QW-1:0] q_sh;

            // The first step compares without a shift.
            assign r_sh = (j == 0) ? rem_reg[j] : rem_reg[j] << 1;
            assign q_sh = (j == 0) ? q_reg[j]   : q_reg[j] << 1;

            always_ff @(posedge aclk) begin
                if (en) begin
                    d_reg[j+1] <= d_reg[j];
                    if (r_sh >= d_reg[j]) begin
                        rem_reg[j+1] <= r_sh - d_reg[j];
                        q_reg[j+1]   <= q_sh | QW'(1);
                    end else begin
                        rem_reg[j+1] <= r_sh;
                        q_reg[j+1]   <= q_sh;
                    end
                end
            end
        end
    endgenerate

    assign q_round = ((QW+1)'(q_reg[NSTEP]) + (QW+1)'(1)) >> 1;

    always_comb begin
        if (d_reg[NSTEP] == '0) begin
            code = '0;
        end else if (q_round > (QW+1)'(ONE_CODE)) begin
            code = ONE_CODE;
        end else begin
            code = q_round[XW-1:0];
        end
    end

endmodule

// ----- rtl/core/smoothing_curve_unit.sv -----
// Top level of the smoothing curve unit: easing curves on a pipelined datapath.
//
//  Channel   Ports                          Direction  Word
//  sample    s_valid s_ready s_position     in         x, 65536 = 1.0 (clamped above)
//  result    m_valid m_ready m_smoothed     out        curve value, same format
//  config    cfg_valid cfg_ready            in         curve_mode, 3 bits, reset 0
//            cfg_curve_mode
//
// A new word can enter every cycle while no result waits at the output. The series
// for the sine curve, eleven term updates of seven stages each, sets the pipeline
// depth, and all curves are aligned to it. Reset clears the valid bits and the
// mode register only. When a result waits at the output, the whole pipeline holds
// its place and s_ready is low; nothing is dropped or repeated.
module smoothing_curve_unit #(
    parameter int FRACTION_BITS = scu_pkg::FRACTION_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [FRACTION_BITS:0] s_position,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [FRACTION_BITS:0] m_smoothed,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [2:0]             cfg_curve_mode
);
    import scu_pkg::*;

    localparam int XW = FRACTION_BITS + 1;
    localparam int XQ_SHIFT = Q_FRAC - FRACTION_BITS;
    localparam logic [XW-1:0] ONE_CODE = XW'(1) << FRACTION_BITS;
    localparam int DIV_LAT = FRACTION_BITS + 3;
    // Stage at which every curve result is ready.
    localparam int LAST = SINE_LAT;
    // Stages, counted from the input register, where each curve finishes.
    localparam int T_QUINTIC = 3 * MUL_LAT;
    localparam int T_SEPTIC  = 3 * MUL_LAT + 1;
    localparam int T_RATIO   = 2 * MUL_LAT + DIV_LAT;

    // Rounds a Q2.62 value to the output code, half up, and clamps it at one.
    function automatic logic [XW-1:0] round_out(input qword_t fv);
        qword_t          sum;
        logic [XW:0]     r;
        sum = fv + (64'd1 << (Q_FRAC - 1 - FRACTION_BITS));
        r = (XW+1)'(sum >> XQ_SHIFT);
        return (r > (XW+1)'(ONE_CODE)) ? ONE_CODE : r[XW-1:0];
    endfunction

    logic                 en;
    curve_mode_t          curve_mode_reg;
    logic                 vld_reg [LAST+1];
    logic [XW-1:0]        xc_reg, xc_next, xc_d2, xc_d4;
    logic                 m_valid_reg;
    logic [XW-1:0]        m_smoothed_reg, m_smoothed_next;

    logic [2*Q_BITS-1:0]  p_x2, p_y2, p_x3, p_x4, p_y3, p_y4, p_f0, p_f1;
    logic [2*XW-1:0]      xcsq;
    qword_t xq, yq, xq_d2, yq_d2, xq_d4;
    qword_t x2, y2, x3, x4, y3, y4;
    qword_t q_poly, q_poly_d, pos, pos_d, neg, c_next, c_reg, x4_d;
    qword_t f0, f1, f2, f0_e, f1_e, div_num, div_oth;
    logic [XW-1:0]        ratio_code, ratio_e;

    // The pipeline advances unless a finished result is still unclaimed.
    assign en        = !m_valid_reg || m_ready;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            curve_mode_reg <= MODE_QUINTIC;
        end else if (cfg_valid && cfg_ready) begin
            curve_mode_reg <= curve_mode_t'(cfg_curve_mode);
        end
    end

    // Valid bits travel alongside the data, one per stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= LAST; k++) begin
                vld_reg[k] <= 1'b0;
            end
            m_valid_reg <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= s_valid;
            for (int k = 1; k <= LAST; k++) begin
                vld_reg[k] <= vld_reg[k-1];
            end
            m_valid_reg <= vld_reg[LAST];
        end
    end

    // Input register: codes above one are taken as exactly one.
    assign xc_next = (s_position > ONE_CODE) ? ONE_CODE : s_position;

    always_ff @(posedge aclk) begin
        if (en) begin
            xc_reg <= xc_next;
        end
    end

    assign xq = Q_BITS'(xc_reg) << XQ_SHIFT;
    assign yq = Q_BITS'(ONE_CODE - xc_reg) << XQ_SHIFT;

    // Squares of x and 1-x, and x*x in plain integer form for the quintic.
    scu_mul #(.WA(Q_BITS), .WB(Q_BITS)) u_mul_x2 (
        .aclk(aclk), .en(en), .a(xq), .b(xq), .p(p_x2));
    scu_mul #(.WA(Q_BITS), .WB(Q_BITS)) u_mul_y2 (
        .aclk(aclk), .en(en), .a(yq), .b(yq), .p(p_y2));
    scu_mul #(.WA(XW), .WB(XW)) u_mul_xx (
        .aclk(aclk), .en(en), .a(xc_reg), .b(xc_reg), .p(xcsq));
    assign x2 = p_x2[Q_FRAC+Q_BITS-1:Q_FRAC];
    assign y2 = p_y2[Q_FRAC+Q_BITS-1:Q_FRAC];

    scu_delay #(.W(XW), .DEPTH(MUL_LAT)) u_xc_dly2 (
        .aclk(aclk), .en(en), .d(xc_reg), .q(xc_d2));
    scu_delay #(.W(XW), .DEPTH(MUL_LAT)) u_xc_dly4 (
        .aclk(aclk), .en(en), .d(xc_d2), .q(xc_d4));
    assign xq_d2 = Q_BITS'(xc_d2) << XQ_SHIFT;
    assign yq_d2 = Q_BITS'(ONE_CODE - xc_d2) << XQ_SHIFT;
    assign xq_d4 = Q_BITS'(xc_d4) << XQ_SHIFT;

    // Third and fourth powers.
    scu_mul #(.WA(Q_BITS), .WB(Q_BITS)) u_mul_x3 (
        .aclk(aclk), .en(en), .a(x2), .b(xq_d2), .p(p_x3));
    scu_mul #(.WA(Q_BITS), .WB(Q_BITS)) u_mul_x4 (
        .aclk(aclk), .en(en), .a(x2), .b(x2), .p(p_x4));
    scu_mul #(.WA(Q_BITS), .WB(Q_BITS)) u_mul_y3 (
        .aclk(aclk), .en(en), .a(y2), .b(yq_d2), .p(p_y3));
    scu_mul #(.WA(Q_BITS), .WB(Q_BITS)) u_mul_y4 (
        .aclk(aclk), .en(en), .a(y2), .b(y2), .p(p_y4));
    assign x3 = p_x3[Q_FRAC+Q_BITS-1:Q_FRAC];
    assign x4 = p_x4[Q_FRAC+Q_BITS-1:Q_FRAC];
    assign y3 = p_y3[Q_FRAC+Q_BITS-1:Q_FRAC];
    assign y4 = p_y4[Q_FRAC+Q_BITS-1:Q_FRAC];

    // Quintic: x^3 * (6x^2 - 15x + 10). The quadratic is always positive.
    assign q_poly = ((Q_BITS'(xcsq) * 64'd6) + (64'd10 << (2 * FRACTION_BITS))
                    - ((Q_BITS'(xc_d2) * 64'd15) << FRACTION_BITS))
                    << (58 - 2 * FRACTION_BITS);

    scu_delay #(.W(Q_BITS), .DEPTH(MUL_LAT)) u_qp_dly (
        .aclk(aclk), .en(en), .d(q_poly), .q(q_poly_d));
    scu_mul #(.WA(Q_BITS), .WB(Q_BITS)) u_mul_f0 (
        .aclk(aclk), .en(en), .a(x3), .b(q_poly_d), .p(p_f0));
    assign f0 = p_f0[58 +: Q_BITS];

    // Septic: x^4 * (35 - 84x + 70x^2 - 20x^3), factor in Q8.56 floored at zero.
    assign pos = (64'd35 << 56) + 64'd70 * (x2 >> 6);
    scu_delay #(.W(Q_BITS), .DEPTH(MUL_LAT)) u_pos_dly (
        .aclk(aclk), .en(en), .d(pos), .q(pos_d));
    assign neg    = 64'd84 * (xq_d4 >> 6) + 64'd20 * (x3 >> 6);
    assign c_next = (pos_d >= neg) ? pos_d - neg : '0;

    always_ff @(posedge aclk) begin
        if (en) begin
            c_reg <= c_next;
        end
    end

    scu_delay #(.W(Q_BITS), .DEPTH(1)) u_x4_dly (
        .aclk(aclk), .en(en), .d(x4), .q(x4_d));
    scu_mul #(.WA(Q_BITS), .WB(Q_BITS)) u_mul_f1 (
        .aclk(aclk), .en(en), .a(x4_d), .b(c_reg), .p(p_f1));
    assign f1 = p_f1[56 +: Q_BITS];

    // Rational curves share one divider; the mode must only change while idle, which the block does not enforce.
    assign div_num = (curve_mode_reg == MODE_QUARTIC_RAT) ? x4 : x3;
    assign div_oth = (curve_mode_reg == MODE_QUARTIC_RAT) ? y4 : y3;

    scu_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
        .aclk(aclk), .en(en), .num(div_num), .oth(div_oth), .code(ratio_code));

    // Sine-corrected curve runs from the input register on its own.
    scu_sine #(.FRACTION_BITS(FRACTION_BITS)) u_sine (
        .aclk(aclk), .en(en), .xc(xc_reg), .f(f2));

    // Bring every curve to the last stage.
    scu_delay #(.W(Q_BITS), .DEPTH(LAST - T_QUINTIC)) u_f0_dly (
        .aclk(aclk), .en(en), .d(f0), .q(f0_e));
    scu_delay #(.W(Q_BITS), .DEPTH(LAST - T_SEPTIC)) u_f1_dly (
        .aclk(aclk), .en(en), .d(f1), .q(f1_e));
    scu_delay #(.W(XW), .DEPTH(LAST - T_RATIO)) u_ratio_dly (
        .aclk(aclk), .en(en), .d(ratio_code), .q(ratio_e));

    // Unused mode codes fall back to the quintic.
    always_comb begin
        case (curve_mode_reg)
            MODE_SEPTIC:      m_smoothed_next = round_out(f1_e);
            MODE_SINE:        m_smoothed_next = round_out(f2);
            MODE_CUBIC_RAT:   m_smoothed_next = ratio_e;
            MODE_QUARTIC_RAT: m_smoothed_next = ratio_e;
            default:          m_smoothed_next = round_out(f0_e);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_smoothed_reg <= m_smoothed_next;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_smoothed = m_smoothed_reg;

    // A waiting result must hold the input side off.
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input accepted while a result waits");

    // An accepted word occupies the first stage on the next edge.
    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> vld_reg[0])
        else $error("accepted word lost at the input register");

    // Results never exceed one.
    a_result_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_smoothed <= ONE_CODE)
        else $error("result above one");

endmodule

// ----- tb/sv/scu_checker.sv -----
// Checker for the smoothing curve unit: watches all channels, predicts and compares results.
module scu_checker
    import scu_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    input  logic                   s_ready,
    input  logic [FRACTION_BITS:0] s_position,
    input  logic                   m_valid,
    input  logic                   m_ready,
    input  logic [FRACTION_BITS:0] m_smoothed,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [2:0]             cfg_curve_mode,
    output int                     fail_count,
    output int                     pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] ONE_CODE = 64'd1 << FRACTION_BITS;
    localparam int          TO_Q     = Q_FRAC - FRACTION_BITS;

    logic [2:0]             mode_shadow;
    logic [FRACTION_BITS:0] expected_curve_q[$];

    function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b,
                                         input int sh);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return 64'(p >> sh);
    endfunction

    function automatic logic [63:0] round_code(input logic [63:0] f);
        logic [63:0] r;
        r = (f + (64'd1 << (TO_Q - 1))) >> TO_Q;
        return (r > ONE_CODE) ? ONE_CODE : r;
    endfunction

    // Restoring division of a by a + b with one guard bit, then round half up.
    function automatic logic [63:0] rational_code(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] d, rem, q;
        d   = a + b;
        rem = a;
        q   = 0;
        if (d == 0) begin
            return 0;
        end
        if (rem >= d) begin
            rem = rem - d;
            q = 1;
        end
        for (int i = 0; i < FRACTION_BITS + 1; i++) begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= d) begin
                rem = rem - d;
                q[0] = 1'b1;
            end
        end
        q = (q + 1) >> 1;
        return (q > ONE_CODE) ? ONE_CODE : q;
    endfunction

    // x - sin(2 pi x)/(2 pi), folded onto the first quarter and summed as sin(t)/t.
    function automatic logic [63:0] sine_code(input logic [63:0] xc, input logic [63:0] xq);
        logic [63:0] u, theta, w, term, acc, g, f;
        logic        add;
        term = Q62_ONE;
        acc  = 0;
        if (xc <= (ONE_CODE >> 2)) begin
            u = xc; add = 1'b0;
        end else if (xc <= (ONE_CODE >> 1)) begin
            u = (ONE_CODE >> 1) - xc; add = 1'b0;
        end else if (xc <= (ONE_CODE >> 1) + (ONE_CODE >> 2)) begin
            u = xc - (ONE_CODE >> 1); add = 1'b1;
        end else begin
            u = ONE_CODE - xc; add = 1'b1;
        end
        theta = qmul(PI_Q60, u, FRACTION_BITS - 3);
        w     = qmul(theta, theta, Q_FRAC);
        for (int k = 0; k < SERIES_TERMS; k++) begin
            if (k % 2 == 0) begin
                acc = acc + term;
            end else begin
                acc = (acc >= term) ? acc - term : 64'd0;
            end
            term = qmul(term, w, Q_FRAC) / 64'((2 * k + 2) * (2 * k + 3));
        end
        g = qmul(u << TO_Q, acc, Q_FRAC);
        if (add) begin
            f = xq + g;
        end else begin
            f = (xq >= g) ? xq - g : 64'd0;
        end
        return round_code(f);
    endfunction

    function automatic logic [FRACTION_BITS:0] curve_value(input logic [2:0] mode,
                                                           input logic [FRACTION_BITS:0] pos);
        logic [63:0] xc, yq, xq, x2, x3, x4, y2, res, pos_sum, neg_sum, c, q;
        xc = 64'(pos);
        if (xc > ONE_CODE) begin
            xc = ONE_CODE;
        end
        xq = xc << TO_Q;
        yq = (ONE_CODE - xc) << TO_Q;
        x2 = qmul(xq, xq, Q_FRAC);
        x3 = qmul(x2, xq, Q_FRAC);
        x4 = qmul(x2, x2, Q_FRAC);
        y2 = qmul(yq, yq, Q_FRAC);
        case (mode)
            MODE_SEPTIC: begin
                pos_sum = (64'd35 << 56) + 64'd70 * (x2 >> 6);
                neg_sum = 64'd84 * (xq >> 6) + 64'd20 * (x3 >> 6);
                c = (pos_sum >= neg_sum) ? pos_sum - neg_sum : 64'd0;
                res = round_code(qmul(x4, c, 56));
            end
            MODE_SINE:        res = sine_code(xc, xq);
            MODE_CUBIC_RAT:   res = rational_code(x3, qmul(y2, yq, Q_FRAC));
            MODE_QUARTIC_RAT: res = rational_code(x4, qmul(y2, y2, Q_FRAC));
            default: begin
                // Unused mode codes fall back to the quintic curve.
                q = 64'd6 * xc * xc + 64'd10 * ONE_CODE * ONE_CODE - 64'd15 * xc * ONE_CODE;
                q = q << (58 - 2 * FRACTION_BITS);
                res = round_code(qmul(x3, q, 58));
            end
        endcase
        return res[FRACTION_BITS:0];
    endfunction

    assign pending = expected_curve_q.size();

    always @(posedge aclk) begin
        logic [FRACTION_BITS:0] want;
        if (!aresetn) begin
            mode_shadow <= MODE_QUINTIC;
            expected_curve_q.delete();
            fail_count <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                mode_shadow <= cfg_curve_mode;
            end
            if (s_valid && s_ready) begin
                expected_curve_q.push_back(curve_value(mode_shadow, s_position));
            end
            if (m_valid && m_ready) begin
                if (expected_curve_q.size() == 0) begin
                    $display("%0t: unexpected result word %0d", $realtime, m_smoothed);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_curve_q.pop_front();
                    if (m_smoothed !== want) begin
                        $display("%0t: smoothed mismatch, expected %0d, actual %0d",
                                 $realtime, want, m_smoothed);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ----- tb/sv/tb.sv -----
// Testbench top of the smoothing curve unit: stimulus, stalls, watchdog and verdict.
module tb;
    import scu_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB          = FRACTION_BITS_DEF;
    localparam int ONE         = 1 << FB;
    // Result latency, taken from SINE_LAT in the package, plus some margin.
    localparam int DRAIN_WAIT  = SINE_LAT + 2 + 20;
    localparam int RANDOM_WORDS = 105;
    localparam int LONG_HOLD   = 400;
    localparam int IDLE_LIMIT  = 5000;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    logic [FB:0]   s_position = '0;
    logic          m_valid;
    logic          m_ready = 1'b0;
    logic [FB:0]   m_smoothed;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic [2:0]    cfg_curve_mode = MODE_QUINTIC;

    int            fail_count;
    int            pending;
    logic          long_hold_req = 1'b0;
    int            idle_cycles = 0;
    int            words_sent = 0;
    int            words_per_mode[8];

    always #5 aclk = ~aclk;

    smoothing_curve_unit #(.FRACTION_BITS(FB)) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_position     (s_position),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_smoothed     (m_smoothed),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_curve_mode (cfg_curve_mode)
    );

    scu_checker #(.FRACTION_BITS(FB)) checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_position     (s_position),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_smoothed     (m_smoothed),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_curve_mode (cfg_curve_mode),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    // Watchdog: any handshake on any channel counts as progress. The limit covers
    // the long receiver hold-off plus a full pipeline drain many times over.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (aresetn) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $realtime, IDLE_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Receiver: alternates between always-ready stretches, light and heavy random
    // stalling. On request it holds off for a long stretch so that the pipeline
    // fills and the block has to drop s_ready.
    initial begin
        int style;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (long_hold_req) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                long_hold_req = 1'b0;
            end else begin
                style = $urandom_range(2);
                repeat ($urandom_range(60, 5)) begin
                    case (style)
                        0: m_ready <= 1'b1;
                        1: m_ready <= ($urandom_range(3) != 0);
                        default: m_ready <= ($urandom_range(3) == 0);
                    endcase
                    @(negedge aclk);
                end
            end
        end
    end

    // Offers one word and holds it until the block takes it. Called at a falling
    // edge and returns at the falling edge after the handshake, with valid still high.
    task automatic offer_sample(input logic [FB:0] pos);
        s_valid    <= 1'b1;
        s_position <= pos;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
        words_per_mode[cfg_curve_mode]++;
        @(negedge aclk);
    endtask

    // Sends a list of words in bursts of random length with random gaps.
    task automatic send_burst_list(input logic [FB:0] list[$]);
        int burst_left;
        burst_left = 0;
        foreach (list[i]) begin
            if (burst_left == 0) begin
                if (s_valid) begin
                    s_valid <= 1'b0;
                    repeat ($urandom_range(8)) @(negedge aclk);
                end
                burst_left = ($urandom_range(4) == 0) ? 40 : $urandom_range(12, 1);
            end
            offer_sample(list[i]);
            burst_left--;
        end
        s_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // The mode is changed only with the pipeline empty.
    task automatic set_mode(input logic [2:0] mode);
        wait (pending == 0);
        repeat (DRAIN_WAIT) @(negedge aclk);
        cfg_valid      <= 1'b1;
        cfg_curve_mode <= mode;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic logic [FB:0] random_position();
        int pick;
        int base;
        pick = $urandom_range(99);
        if (pick < 70) begin
            return (FB + 1)'($urandom_range(ONE));
        end else if (pick < 85) begin
            // Near the quarter points, where the sine fold changes branch.
            base = (ONE / 4) * $urandom_range(4);
            return (FB + 1)'(base + $urandom_range(6) - 3);
        end else begin
            return (FB + 1)'($urandom);
        end
    endfunction

    initial begin
        logic [FB:0] list[$];
        logic [2:0]  phase_mode[$];
        phase_mode = '{MODE_QUINTIC, MODE_SEPTIC, MODE_SINE, MODE_CUBIC_RAT,
                       MODE_QUARTIC_RAT, 3'd6, 3'd7, 3'd5, MODE_QUINTIC};
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (phase_mode[p]) begin
            // The first phase runs on the mode left by reset.
            if (p != 0) begin
                set_mode(phase_mode[p]);
            end

            // Directed words: ends of the range, the fold points of the sine curve,
            // and codes above one, which must clamp to one.
            list = '{0, 1, ONE / 4, ONE / 2, 3 * ONE / 4, ONE - 1, ONE, ONE + 1,
                     (1 << (FB + 1)) - 1};
            if (p >= 5) begin
                list = '{0, ONE / 2, (1 << (FB + 1)) - 1};
            end
            send_burst_list(list);

            if (p == 2) begin
                long_hold_req = 1'b1;
            end
            list.delete();
            for (int i = 0; i < RANDOM_WORDS; i++) begin
                list.push_back(random_position());
            end
            if (p == 3) begin
                // Mid-phase pause until every outstanding result is back.
                send_burst_list(list[0:59]);
                wait (pending == 0);
                @(negedge aclk);
                send_burst_list(list[60:$]);
            end else begin
                send_burst_list(list);
            end
        end

        wait (pending == 0);
        repeat (DRAIN_WAIT) @(negedge aclk);

        $display("Sent %0d words: quintic %0d, septic %0d, sine %0d, cubic %0d, quartic %0d,",
                 words_sent, words_per_mode[0], words_per_mode[1], words_per_mode[2],
                 words_per_mode[3], words_per_mode[4]);
        $display("and %0d on unused mode codes; one long output hold-off and one full drain.",
                 words_per_mode[5] + words_per_mode[6] + words_per_mode[7]);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/scu_pkg.sv
rtl/core/scu_mul.sv
rtl/core/scu_delay.sv
rtl/core/scu_term.sv
rtl/core/scu_sine.sv
rtl/core/scu_div.sv
rtl/core/smoothing_curve_unit.sv
tb/sv/scu_checker.sv
tb/sv/tb.sv
